// ===== src/four_level_page_walker_assert.svh =====
`ifndef FOUR_LEVEL_PAGE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALKER_ASSERT_SVH

// Checks that a condition in one cycle implies a consequence in the same cycle.
`define FLPW_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page walker assertion failed");

// Checks that a condition in one cycle implies a consequence in the next cycle.
`define FLPW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page walker assertion failed");

`endif

// ===== src/flpw_pkg.sv =====
`timescale 1ns / 1ps

package flpw_pkg;

	localparam int VA_BITS = 48;
	localparam int OUT_ADDR_BITS = 48;
	localparam int ENTRY_BITS = 64;
	localparam int INDEX_BITS = 9;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] SIZE_4K = 2'd0;
	localparam logic [1:0] SIZE_2M = 2'd1;
	localparam logic [1:0] SIZE_1G = 2'd2;

	localparam logic [1:0] LEVEL_TOP = 2'd0;
	localparam logic [1:0] LEVEL_1G = 2'd1;
	localparam logic [1:0] LEVEL_2M = 2'd2;
	localparam logic [1:0] LEVEL_LEAF = 2'd3;

	localparam int PRESENT_BIT = 0;
	localparam int LARGE_BIT = 7;

	localparam logic [OUT_ADDR_BITS-1:0] OFFSET_MASK_4K = 48'h0000_0000_0FFF;
	localparam logic [OUT_ADDR_BITS-1:0] OFFSET_MASK_2M = 48'h0000_001F_FFFF;
	localparam logic [OUT_ADDR_BITS-1:0] OFFSET_MASK_1G = 48'h0000_3FFF_FFFF;

	typedef struct packed {
		logic                     req_type;
		logic [VA_BITS-1:0]       lin_addr;
		logic [OUT_ADDR_BITS-1:0] table_root;
		logic [ENTRY_BITS-1:0]    entry_data;
	} req_item_t;

	typedef struct packed {
		logic                     out_kind;
		logic [OUT_ADDR_BITS-1:0] read_addr;
		logic [1:0]               walk_level;
		logic [OUT_ADDR_BITS-1:0] xlat_addr;
		logic                     fault;
		logic [1:0]               page_size;
	} rsp_item_t;

	typedef struct packed {
		logic               busy;
		logic [1:0]         level;
		logic [VA_BITS-1:0] vaddr;
	} walk_state_t;

	// Nine-bit table index of the virtual address for a given level.
	function automatic logic [INDEX_BITS-1:0] table_index(input logic [VA_BITS-1:0] va,
			input logic [1:0] lvl);
		logic [INDEX_BITS-1:0] idx;
		case (lvl)
			LEVEL_TOP:  idx = va[47:39];
			LEVEL_1G:   idx = va[38:30];
			LEVEL_2M:   idx = va[29:21];
			LEVEL_LEAF: idx = va[20:12];
			default:    idx = '0;
		endcase
		return idx;
	endfunction

	// Byte address of an entry: table base plus index times eight.
	function automatic logic [OUT_ADDR_BITS-1:0] entry_addr(
			input logic [OUT_ADDR_BITS-1:0] base, input logic [INDEX_BITS-1:0] idx);
		return base + {{(OUT_ADDR_BITS - INDEX_BITS - 3){1'b0}}, idx, 3'b000};
	endfunction

endpackage

// ===== src/flpw_chan_if.sv =====
`timescale 1ns / 1ps

interface flpw_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/flpw_step.sv =====
`timescale 1ns / 1ps

module flpw_step import flpw_pkg::*; #(
	parameter int PHYS_ADDR_BITS = 48
) (
	input  req_item_t   item,
	input  walk_state_t state,
	output logic        has_result,
	output rsp_item_t   result,
	output walk_state_t next_state
);

	// Address bits above the physical width are dropped; outputs never exceed 48 bits.
	localparam logic [OUT_ADDR_BITS-1:0] AddrMask = (PHYS_ADDR_BITS >= OUT_ADDR_BITS) ?
		{OUT_ADDR_BITS{1'b1}} :
		OUT_ADDR_BITS'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

	logic [OUT_ADDR_BITS-1:0] root_base;
	logic [OUT_ADDR_BITS-1:0] entry_addr_bits;
	logic [OUT_ADDR_BITS-1:0] frame_4k;
	logic [1:0]               next_level;
	logic                     present;
	logic                     big_page;

	assign root_base       = item.table_root & AddrMask & ~OFFSET_MASK_4K;
	assign entry_addr_bits = item.entry_data[OUT_ADDR_BITS-1:0] & AddrMask;
	assign frame_4k        = entry_addr_bits & ~OFFSET_MASK_4K;
	assign next_level      = state.level + 2'd1;
	assign present         = item.entry_data[PRESENT_BIT];
	assign big_page        = item.entry_data[LARGE_BIT];

	always_comb begin
		has_result = 1'b0;
		result     = '0;
		next_state = state;
		if (item.req_type == REQ_START) begin
			// A start always wins, abandoning any walk in progress.
			has_result         = 1'b1;
			result.out_kind    = KIND_READ;
			result.read_addr   = entry_addr(root_base, table_index(item.lin_addr, LEVEL_TOP));
			result.walk_level  = LEVEL_TOP;
			next_state.busy    = 1'b1;
			next_state.level   = LEVEL_TOP;
			next_state.vaddr   = item.lin_addr;
		end else if (state.busy) begin
			has_result        = 1'b1;
			result.walk_level = state.level;
			if (!present) begin
				result.out_kind = KIND_DONE;
				result.fault    = 1'b1;
				next_state.busy = 1'b0;
			end else if (state.level == LEVEL_1G && big_page) begin
				result.out_kind  = KIND_DONE;
				result.page_size = SIZE_1G;
				result.xlat_addr = ((entry_addr_bits & ~OFFSET_MASK_1G) |
					(state.vaddr & OFFSET_MASK_1G)) & AddrMask;
				next_state.busy  = 1'b0;
			end else if (state.level == LEVEL_2M && big_page) begin
				result.out_kind  = KIND_DONE;
				result.page_size = SIZE_2M;
				result.xlat_addr = ((entry_addr_bits & ~OFFSET_MASK_2M) |
					(state.vaddr & OFFSET_MASK_2M)) & AddrMask;
				next_state.busy  = 1'b0;
			end else if (state.level == LEVEL_LEAF) begin
				result.out_kind  = KIND_DONE;
				result.page_size = SIZE_4K;
				result.xlat_addr = (frame_4k | (state.vaddr & OFFSET_MASK_4K)) & AddrMask;
				next_state.busy  = 1'b0;
			end else begin
				result.out_kind   = KIND_READ;
				result.walk_level = next_level;
				result.read_addr  = entry_addr(frame_4k, table_index(state.vaddr, next_level));
				next_state.level  = next_level;
			end
		end
	end

endmodule

// ===== src/four_level_page_walker.sv =====
// Four-level page walker: one start or returned-entry transaction per cycle, sustained while
// the result side is not stalled. An accepted transaction passes through the input register,
// where the walk step is evaluated, and then the result register before it appears on rsp.
// An entry that arrives while no walk is active is consumed without a result.
// Reset clears the valid flags of both registers and the walk state (idle, level zero).
`timescale 1ns / 1ps

module four_level_page_walker import flpw_pkg::*; #(
	parameter int PHYS_ADDR_BITS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	flpw_chan_if.sink    req,
	flpw_chan_if.source  rsp
);

	req_item_t   item_s1;
	logic        valid_s1;
	walk_state_t state_q;
	walk_state_t state_next;
	rsp_item_t   rsp_next;
	rsp_item_t   rsp_q;
	logic        rsp_valid_q;
	logic        has_result;
	logic        out_free;
	logic        advance;

	flpw_step #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_step (
		.item       (item_s1),
		.state      (state_q),
		.has_result (has_result),
		.result     (rsp_next),
		.next_state (state_next)
	);

	// The input stage retires when its result, if any, has a free slot to go to.
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign advance   = valid_s1 && (!has_result || out_free);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// ===== src/flpw_checker.sv =====
`timescale 1ns / 1ps
`include "four_level_page_walker_assert.svh"

module flpw_checker import flpw_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp_data
);

	// A stalled result transaction keeps its contents.
	`FLPW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// Read requests carry only an aligned address.
	`FLPW_ASSERT_SAME(a_read_clean, rsp_valid && rsp_data.out_kind == KIND_READ,
		rsp_data.xlat_addr == '0 && !rsp_data.fault && rsp_data.page_size == SIZE_4K &&
		rsp_data.read_addr[2:0] == 3'b000)

	// A fault reports no translation.
	`FLPW_ASSERT_SAME(a_fault_clean, rsp_valid && rsp_data.out_kind == KIND_DONE &&
		rsp_data.fault, rsp_data.xlat_addr == '0 && rsp_data.page_size == SIZE_4K &&
		rsp_data.read_addr == '0)

	// Large pages end only at their own level; 4 KB pages only at the leaf level.
	`FLPW_ASSERT_SAME(a_size_level, rsp_valid && rsp_data.out_kind == KIND_DONE &&
		!rsp_data.fault,
		(rsp_data.page_size == SIZE_1G && rsp_data.walk_level == LEVEL_1G) ||
		(rsp_data.page_size == SIZE_2M && rsp_data.walk_level == LEVEL_2M) ||
		(rsp_data.page_size == SIZE_4K && rsp_data.walk_level == LEVEL_LEAF))

endmodule

bind four_level_page_walker flpw_checker u_flpw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== bench/four_level_page_walker_tb.sv =====
`timescale 1ns / 1ps

module four_level_page_walker_tb;
	import flpw_pkg::*;

	localparam int PA_BITS = 48;
	localparam logic [47:0] PA_MASK = (PA_BITS >= 48) ? '1 : ((48'd1 << PA_BITS) - 48'd1);
	localparam int TAIL_CYCLES = 8;
	localparam int N_DIR = 25;
	localparam int ITEMS_PER_PHASE = 242;

	typedef struct packed {
		logic      typed;
		req_item_t item;
		rsp_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	flpw_chan_if #(.T(req_item_t)) req_if ();
	flpw_chan_if #(.T(rsp_item_t)) rsp_if ();

	four_level_page_walker #(.PHYS_ADDR_BITS(PA_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #4 clk = ~clk;

	// Walk state as the testbench tracks it.
	logic        walk_active;
	logic [1:0]  walk_depth;
	logic [47:0] walk_vaddr;

	rsp_item_t awaited_rsp[$];
	int        src_idle_pct;
	int        snk_idle_pct;
	int        errors;
	int        n_answered;
	int        n_sent;
	int        n_starts;
	int        n_reads;
	int        n_faults;
	int        n_pages[3];

	// Extremes, 1G and 2M pages, faults at the top and bottom, and the corner behaviors.
	dir_row_t dir_rows [N_DIR] = '{
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF}, '0},
		'{1'b1, '{REQ_START, 48'h0, 48'h0, 64'h0},
			'{KIND_READ, 48'h0, LEVEL_TOP, 48'h0, 1'b0, SIZE_4K}},
		'{1'b1, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0},
			'{KIND_DONE, 48'h0, LEVEL_TOP, 48'h0, 1'b1, SIZE_4K}},
		'{1'b1, '{REQ_START, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'h0},
			'{KIND_READ, 48'hFFFF_FFFF_FFF8, LEVEL_TOP, 48'h0, 1'b0, SIZE_4K}},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'hFFFF_0000_0020_0081}, '0},
		'{1'b0, '{REQ_START, 48'h0000_4030_2010, 48'h0000_1234_5FFF, 64'h0}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h8000_0000_0000_0083}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_00FF_C000_0081}, '0},
		'{1'b0, '{REQ_START, 48'h8000_0000_0ABC, 48'h0000_0000_1000, 64'h0}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_3001}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0004_5001}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h7FF0_ABCD_E000_0081}, '0},
		'{1'b0, '{REQ_START, 48'h1234_5678_9ABC, 48'h0, 64'h0}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b0, '{REQ_START, 48'hFFFF_0000_FFFF, 48'h0000_0002_0000, 64'h0}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b1, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0},
			'{KIND_DONE, 48'h0, LEVEL_LEAF, 48'h0, 1'b1, SIZE_4K}},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b0, '{REQ_START, 48'h0, 48'h0, 64'h0}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0001}, '0},
		'{1'b0, '{REQ_ENTRY, 48'h0, 48'h0, 64'h0000_0000_0000_0080}, '0}
	};

	function automatic logic [47:0] rand48();
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom;
		lo = $urandom;
		return {hi[15:0], lo};
	endfunction

	// Byte offset of the entry that the virtual address selects within a table of a level.
	function automatic logic [47:0] entry_offset(input logic [47:0] va, input logic [1:0] lvl);
		return ((va >> (39 - 9 * int'(lvl))) & 48'h1FF) << 3;
	endfunction

	function automatic void walk_step(input req_item_t it, output bit produced,
			output rsp_item_t r);
		logic [63:0] e;
		logic [47:0] frame;
		logic [47:0] e_addr;
		r = '0;
		produced = 1'b0;
		if (it.req_type == REQ_START) begin
			walk_vaddr = it.lin_addr;
			walk_depth = LEVEL_TOP;
			walk_active = 1'b1;
			r.out_kind = KIND_READ;
			r.walk_level = LEVEL_TOP;
			r.read_addr = (it.table_root & PA_MASK & ~OFFSET_MASK_4K)
				+ entry_offset(walk_vaddr, LEVEL_TOP);
			produced = 1'b1;
			return;
		end
		if (!walk_active)
			return;
		produced = 1'b1;
		e = it.entry_data;
		e_addr = e[47:0] & PA_MASK;
		frame = e_addr & ~OFFSET_MASK_4K;
		r.walk_level = walk_depth;
		r.out_kind = KIND_DONE;
		if (!e[PRESENT_BIT]) begin
			walk_active = 1'b0;
			r.fault = 1'b1;
		end else if (walk_depth == LEVEL_1G && e[LARGE_BIT]) begin
			walk_active = 1'b0;
			r.xlat_addr = ((e_addr & ~OFFSET_MASK_1G) | (walk_vaddr & OFFSET_MASK_1G)) & PA_MASK;
			r.page_size = SIZE_1G;
		end else if (walk_depth == LEVEL_2M && e[LARGE_BIT]) begin
			walk_active = 1'b0;
			r.xlat_addr = ((e_addr & ~OFFSET_MASK_2M) | (walk_vaddr & OFFSET_MASK_2M)) & PA_MASK;
			r.page_size = SIZE_2M;
		end else if (walk_depth == LEVEL_LEAF) begin
			walk_active = 1'b0;
			r.xlat_addr = (frame | (walk_vaddr & OFFSET_MASK_4K)) & PA_MASK;
			r.page_size = SIZE_4K;
		end else begin
			walk_depth = walk_depth + 2'd1;
			r.out_kind = KIND_READ;
			r.walk_level = walk_depth;
			r.read_addr = frame + entry_offset(walk_vaddr, walk_depth);
		end
	endfunction

	task automatic send_req(input req_item_t it, input bit typed = 1'b0,
			input rsp_item_t want = '0);
		bit        produced;
		rsp_item_t r;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= it;
		do @(posedge clk); while (!req_if.ready);
		walk_step(it, produced, r);
		n_sent++;
		if (it.req_type == REQ_START)
			n_starts++;
		if (produced) begin
			awaited_rsp.push_back(typed ? want : r);
			n_answered++;
		end
	endtask

	// Holds the sender off until every outstanding result has been checked.
	task automatic settle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic random_items(input int target);
		int        base_cnt;
		int        depth;
		int        roll;
		req_item_t it;
		base_cnt = n_sent;
		while (n_sent - base_cnt < target) begin
			roll = $urandom_range(99);
			it = {1'b0, rand48(), rand48(), $urandom, $urandom};
			if (roll < 80) begin
				it.req_type = REQ_START;
				send_req(it);
				depth = 0;
				while (walk_active && depth < 4) begin
					it = {1'b0, rand48(), rand48(), $urandom, $urandom};
					it.req_type = REQ_ENTRY;
					it.entry_data[PRESENT_BIT] = ($urandom_range(99) < 92);
					it.entry_data[LARGE_BIT] = ($urandom_range(99) < 30);
					// Now and then the walk is left hanging so the next start abandons it.
					if ($urandom_range(99) < 4)
						break;
					send_req(it);
					depth++;
				end
			end else begin
				if (roll < 90)
					it.req_type = REQ_ENTRY;
				else
					it.req_type = 1'($urandom_range(1));
				send_req(it);
			end
		end
	endtask

	function automatic int field_bad(input string nm, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got)
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, nm, want, got);
		return int'(want !== got);
	endfunction

	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin : rsp_monitor
		rsp_item_t got;
		rsp_item_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $realtime, got);
				errors++;
			end else begin
				want = awaited_rsp.pop_front();
				errors += field_bad("out_kind", want.out_kind, got.out_kind);
				errors += field_bad("read_addr", want.read_addr, got.read_addr);
				errors += field_bad("walk_level", want.walk_level, got.walk_level);
				errors += field_bad("xlat_addr", want.xlat_addr, got.xlat_addr);
				errors += field_bad("fault", want.fault, got.fault);
				errors += field_bad("page_size", want.page_size, got.page_size);
				if (want.out_kind == KIND_READ)
					n_reads++;
				else if (want.fault)
					n_faults++;
				else if (want.page_size <= SIZE_1G)
					n_pages[want.page_size]++;
			end
		end
	end

	initial begin
		#2000000;
		$display("four_level_page_walker regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		walk_active = 1'b0;
		walk_depth = LEVEL_TOP;
		walk_vaddr = '0;
		errors = 0;
		n_answered = 0;
		n_sent = 0;
		n_starts = 0;
		n_reads = 0;
		n_faults = 0;
		n_pages = '{0, 0, 0};
		src_idle_pct = 31;
		snk_idle_pct = 66;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		settle();

		random_items(ITEMS_PER_PHASE);
		settle();
		src_idle_pct = 66;
		snk_idle_pct = 31;
		random_items(ITEMS_PER_PHASE);
		settle();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_items(ITEMS_PER_PHASE);
		settle();

		$display("Walked %0d starts: %0d entry reads, %0d faults, 4K/2M/1G pages %0d/%0d/%0d.",
			n_starts, n_reads, n_faults, n_pages[0], n_pages[1], n_pages[2]);
		$display("Idle mixes: sender 31%%/receiver 66%%, then 66%%/31%%, then back to back.");
		if (errors == 0)
			$display("four_level_page_walker regression: pass");
		else
			$display("four_level_page_walker regression: fail");
		$finish;
	end

endmodule
